// ===== rtl/eop_pkg.sv =====
// Package with parse phases and TIFF/EXIF constants for the orientation parser.
`timescale 1ns / 1ps

package eop_pkg;

  // Parse phases of the header and first directory
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_WAIT    = 3'd1,
    PH_COUNT   = 3'd2,
    PH_ENTRIES = 3'd3,
    PH_TAIL    = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  localparam logic [15:0] ORIENT_TAG     = 16'h0112;
  localparam logic [15:0] TIFF_MAGIC     = 16'd42;
  localparam logic [3:0]  ENTRY_LAST     = 4'd11;   // last byte index of a 12-byte entry
  localparam logic [15:0] SHORT_TYPE     = 16'd3;
  localparam logic [31:0] MIN_DIR_OFFSET = 32'd8;
  localparam logic [15:0] MAX_ORIENT     = 16'd8;
  localparam logic [7:0]  MARK_II        = 8'h49;   // 'I'
  localparam logic [7:0]  MARK_MM        = 8'h4D;   // 'M'
  localparam logic [3:0]  COUNT_BYTES    = 4'd2;
  localparam logic [3:0]  TAIL_BYTES     = 4'd4;

  // Entry byte indexes at which fields complete
  localparam logic [3:0]  EB_TAG   = 4'd1;
  localparam logic [3:0]  EB_TYPE  = 4'd3;
  localparam logic [3:0]  EB_COUNT = 4'd7;
  localparam logic [3:0]  EB_VALUE = 4'd9;

endpackage

// ===== rtl/exif_orientation_parser.sv =====
// Top level: byte-stream TIFF/EXIF header parser that reports the orientation tag.
`timescale 1ns / 1ps

// Channel   Direction  Payload                                   Transaction
// s_axis    in         tdata[7:0] data_byte, tlast last_byte      one block byte
// m_axis    out        tdata[0] invalid, [1] present, [5:2] orient one result per block
//
// One byte is taken every cycle unless a final byte waits on a held result.
// A byte is parsed from the input register; a final byte puts its result in
// the output register when it is parsed. Reset clears the parse state and empties
// both registers. A held result stalls the input only when the next byte to
// be parsed is itself a final byte; other bytes keep flowing past it.

module exif_orientation_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] invalid, [1] present, [5:2] orientation, [7:6] 0
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register
  logic       out_valid_q;
  logic       out_invalid_q;
  logic       out_present_q;
  logic [3:0] out_orient_q;

  // Parse state
  eop_pkg::phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic        big_q, big_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] dir_q, dir_d;
  logic [15:0] total_q, total_d;
  logic [15:0] num_q, num_d;
  logic [3:0]  eb_q, eb_d;
  logic        fok_q, fok_d;
  logic        tag_q, tag_d;
  logic [3:0]  found_q, found_d;
  logic        err_q, err_d;
  logic [7:0]  mark_q, mark_d;

  logic        out_free;
  logic        proc_fire;
  logic        in_fire;
  logic [31:0] gath;
  logic [15:0] f16;
  logic [15:0] num_inc;
  logic        bad;

  // Handshake
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc_fire       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || proc_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Field gathering in the current byte order
  assign gath    = big_q ? {shift_q[23:0], in_byte_q} : {in_byte_q, shift_q[31:8]};
  assign f16     = big_q ? gath[15:0] : gath[31:16];
  assign num_inc = num_q + 16'd1;

  // Next parse state for the registered byte
  always_comb begin
    phase_d = phase_q;
    pos_d   = (pos_q != 32'hFFFF_FFFF) ? pos_q + 32'd1 : pos_q;
    big_d   = big_q;
    shift_d = shift_q;
    dir_d   = dir_q;
    total_d = total_q;
    num_d   = num_q;
    eb_d    = eb_q;
    fok_d   = fok_q;
    tag_d   = tag_q;
    found_d = found_q;
    err_d   = err_q;
    mark_d  = mark_q;
    case (phase_q)
      eop_pkg::PH_HEADER: begin
        if (pos_q == 32'd0) begin
          mark_d = in_byte_q;
        end else if (pos_q == 32'd1) begin
          if (mark_q == eop_pkg::MARK_II && in_byte_q == eop_pkg::MARK_II) begin
            big_d = 1'b0;
          end else if (mark_q == eop_pkg::MARK_MM && in_byte_q == eop_pkg::MARK_MM) begin
            big_d = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end else begin
          shift_d = gath;
          if (pos_q == 32'd3 && f16 != eop_pkg::TIFF_MAGIC) err_d = 1'b1;
          if (pos_q == 32'd7) begin
            dir_d = gath;
            if (gath < eop_pkg::MIN_DIR_OFFSET) err_d = 1'b1;
            phase_d = eop_pkg::PH_WAIT;
          end
        end
      end
      eop_pkg::PH_WAIT: begin
        // the directory's first byte is also the first count byte
        if (pos_q == dir_q) begin
          shift_d = gath;
          eb_d    = 4'd1;
          phase_d = eop_pkg::PH_COUNT;
        end
      end
      eop_pkg::PH_COUNT: begin
        shift_d = gath;
        if (eb_q + 4'd1 >= eop_pkg::COUNT_BYTES) begin
          total_d = f16;
          num_d   = 16'd0;
          eb_d    = 4'd0;
          phase_d = (f16 == 16'd0) ? eop_pkg::PH_TAIL : eop_pkg::PH_ENTRIES;
        end else begin
          eb_d = eb_q + 4'd1;
        end
      end
      eop_pkg::PH_ENTRIES: begin
        shift_d = gath;
        case (eb_q)
          eop_pkg::EB_TAG: begin
            tag_d = (f16 == eop_pkg::ORIENT_TAG);
            if (f16 == eop_pkg::ORIENT_TAG && found_q != 4'd0) err_d = 1'b1;
          end
          eop_pkg::EB_TYPE: begin
            if (f16 != eop_pkg::SHORT_TYPE) fok_d = 1'b0;
          end
          eop_pkg::EB_COUNT: begin
            if (gath != 32'd1) fok_d = 1'b0;
          end
          eop_pkg::EB_VALUE: begin
            if (tag_q) begin
              if (fok_q && f16 >= 16'd1 && f16 <= eop_pkg::MAX_ORIENT) begin
                found_d = f16[3:0];
              end else begin
                err_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
        if (eb_q >= eop_pkg::ENTRY_LAST) begin
          eb_d  = 4'd0;
          fok_d = 1'b1;
          tag_d = 1'b0;
          num_d = num_inc;
          if (num_inc >= total_q) phase_d = eop_pkg::PH_TAIL;
        end else begin
          eb_d = eb_q + 4'd1;
        end
      end
      eop_pkg::PH_TAIL: begin
        if (eb_q + 4'd1 >= eop_pkg::TAIL_BYTES) begin
          eb_d    = 4'd0;
          phase_d = eop_pkg::PH_DONE;
        end else begin
          eb_d = eb_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign bad = err_d || (phase_d != eop_pkg::PH_DONE);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Parse state; the final byte of a block returns it to reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= eop_pkg::PH_HEADER;
      pos_q   <= '0;
      big_q   <= 1'b0;
      shift_q <= '0;
      dir_q   <= '0;
      total_q <= '0;
      num_q   <= '0;
      eb_q    <= '0;
      fok_q   <= 1'b1;
      tag_q   <= 1'b0;
      found_q <= '0;
      err_q   <= 1'b0;
      mark_q  <= '0;
    end else if (proc_fire) begin
      if (in_last_q) begin
        phase_q <= eop_pkg::PH_HEADER;
        pos_q   <= '0;
        big_q   <= 1'b0;
        shift_q <= '0;
        dir_q   <= '0;
        total_q <= '0;
        num_q   <= '0;
        eb_q    <= '0;
        fok_q   <= 1'b1;
        tag_q   <= 1'b0;
        found_q <= '0;
        err_q   <= 1'b0;
        mark_q  <= '0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        big_q   <= big_d;
        shift_q <= shift_d;
        dir_q   <= dir_d;
        total_q <= total_d;
        num_q   <= num_d;
        eb_q    <= eb_d;
        fok_q   <= fok_d;
        tag_q   <= tag_d;
        found_q <= found_d;
        err_q   <= err_d;
        mark_q  <= mark_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && in_last_q) begin
      out_invalid_q <= bad;
      out_present_q <= !bad && (found_d != 4'd0);
      out_orient_q  <= bad ? 4'd0 : found_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_orient_q, out_present_q, out_invalid_q};

endmodule

// ===== verif/tb_exif_orientation_parser.sv =====
// Self-checking testbench for the TIFF/EXIF orientation tag parser.
`timescale 1ns / 1ps

module tb_exif_orientation_parser;

  // One parse result, laid out as m_axis_tdata[5:0]
  typedef struct packed {
    logic [3:0] orientation;
    logic       present;
    logic       invalid;
  } orient_res_t;

  // One byte of stimulus; res is typed in only where typed is set
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    orient_res_t res;
  } byte_item_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_COMB
  } rx_mode_e;

  localparam orient_res_t RES_NONE   = '{orientation: 4'd0, present: 1'b0, invalid: 1'b0};
  localparam orient_res_t RES_BAD    = '{orientation: 4'd0, present: 1'b0, invalid: 1'b1};
  localparam int          RAND_BYTES = 1350;
  localparam int          HOLDOFF    = 400;
  localparam int          DRAIN      = 20;

  // Directed blocks: zero entries with a trailing byte, one-byte blocks at
  // both byte extremes, and a big-endian header with an all-ones offset
  localparam int         DIR_LEN = 25;
  localparam byte_item_t DIR_ROWS [DIR_LEN] = '{
    '{eop_pkg::MARK_II, 1'b0, 1'b0, RES_NONE},
    '{eop_pkg::MARK_II, 1'b0, 1'b0, RES_NONE},
    '{8'd42,   1'b0, 1'b0, RES_NONE},
    '{8'h00,   1'b0, 1'b0, RES_NONE},
    '{8'h08,   1'b0, 1'b0, RES_NONE},
    '{8'h00,   1'b0, 1'b0, RES_NONE},
    '{8'h00,   1'b0, 1'b0, RES_NONE},
    '{8'h00,   1'b0, 1'b0, RES_NONE},
    '{8'h00,   1'b0, 1'b0, RES_NONE},
    '{8'h00,   1'b0, 1'b0, RES_NONE},
    '{8'hFF,   1'b0, 1'b0, RES_NONE},
    '{8'hFF,   1'b0, 1'b0, RES_NONE},
    '{8'hFF,   1'b0, 1'b0, RES_NONE},
    '{8'hFF,   1'b0, 1'b0, RES_NONE},
    '{8'hA5,   1'b1, 1'b1, RES_NONE},
    '{8'h00,   1'b1, 1'b1, RES_BAD},
    '{eop_pkg::MARK_MM, 1'b0, 1'b0, RES_NONE},
    '{eop_pkg::MARK_MM, 1'b0, 1'b0, RES_NONE},
    '{8'h00,   1'b0, 1'b0, RES_NONE},
    '{8'd42,   1'b0, 1'b0, RES_NONE},
    '{8'hFF,   1'b0, 1'b0, RES_NONE},
    '{8'hFF,   1'b0, 1'b0, RES_NONE},
    '{8'hFF,   1'b0, 1'b0, RES_NONE},
    '{8'hFF,   1'b1, 1'b1, RES_BAD},
    '{8'hFF,   1'b1, 1'b1, RES_BAD}
  };

  logic       clk_i     = 1'b0;
  logic       rst_n     = 1'b0;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'h00;
  logic       s_tlast   = 1'b0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;

  byte_item_t  byte_q [$];
  orient_res_t orient_exp_q [$];
  logic [7:0]  blk_q [$];
  logic        gen_be;
  int          err_cnt      = 0;
  int          results_seen = 0;

  // Parser mirror state
  logic [31:0]     pos_cnt;
  logic            be_order;
  logic [31:0]     shreg;
  logic [31:0]     dir_off;
  logic [15:0]     n_entries;
  logic [15:0]     entry_idx;
  logic [3:0]      byte_idx;
  logic            fields_good;
  logic            is_orient;
  logic [3:0]      orient_val;
  logic            malformed;
  eop_pkg::phase_e ph;
  logic [7:0]      mark0;

  exif_orientation_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror
  // ---------------------------------------------------------------------------

  task automatic clear_parser();
    pos_cnt     = '0;
    be_order    = 1'b0;
    shreg       = '0;
    dir_off     = '0;
    n_entries   = '0;
    entry_idx   = '0;
    byte_idx    = '0;
    fields_good = 1'b1;
    is_orient   = 1'b0;
    orient_val  = '0;
    malformed   = 1'b0;
    ph          = eop_pkg::PH_HEADER;
    mark0       = '0;
  endtask

  // Multi-byte fields gather in byte order
  task automatic shift_in(input logic [7:0] b);
    if (be_order) shreg = {shreg[23:0], b};
    else          shreg = {b, shreg[31:8]};
  endtask

  // 16-bit field from the last two bytes gathered
  function automatic logic [15:0] half_word();
    return be_order ? shreg[15:0] : shreg[31:16];
  endfunction

  task automatic parse_tiff_byte(input logic [7:0] b, input logic last,
                                 output bit done, output orient_res_t res);
    logic [15:0] hw;
    logic        bad;
    done = 1'b0;
    res  = RES_NONE;
    case (ph)
      eop_pkg::PH_HEADER: begin
        if (pos_cnt == 32'd0) begin
          mark0 = b;
        end else if (pos_cnt == 32'd1) begin
          if (mark0 == eop_pkg::MARK_II && b == eop_pkg::MARK_II)      be_order = 1'b0;
          else if (mark0 == eop_pkg::MARK_MM && b == eop_pkg::MARK_MM) be_order = 1'b1;
          else                                                         malformed = 1'b1;
        end else begin
          shift_in(b);
          if (pos_cnt == 32'd3 && half_word() != eop_pkg::TIFF_MAGIC) malformed = 1'b1;
          if (pos_cnt == 32'd7) begin
            dir_off = shreg;
            if (dir_off < eop_pkg::MIN_DIR_OFFSET) malformed = 1'b1;
            ph = eop_pkg::PH_WAIT;
          end
        end
      end
      eop_pkg::PH_WAIT, eop_pkg::PH_COUNT: begin
        // the byte at the directory offset is already the first count byte
        if (ph == eop_pkg::PH_WAIT && pos_cnt == dir_off) begin
          ph       = eop_pkg::PH_COUNT;
          byte_idx = '0;
        end
        if (ph == eop_pkg::PH_COUNT) begin
          shift_in(b);
          byte_idx = byte_idx + 4'd1;
          if (byte_idx >= eop_pkg::COUNT_BYTES) begin
            n_entries = half_word();
            entry_idx = '0;
            byte_idx  = '0;
            ph        = (n_entries == 16'd0) ? eop_pkg::PH_TAIL : eop_pkg::PH_ENTRIES;
          end
        end
      end
      eop_pkg::PH_ENTRIES: begin
        shift_in(b);
        case (byte_idx)
          eop_pkg::EB_TAG: begin
            is_orient = (half_word() == eop_pkg::ORIENT_TAG);
            if (is_orient && orient_val != 4'd0) malformed = 1'b1;
          end
          eop_pkg::EB_TYPE:  if (half_word() != eop_pkg::SHORT_TYPE) fields_good = 1'b0;
          eop_pkg::EB_COUNT: if (shreg != 32'd1) fields_good = 1'b0;
          eop_pkg::EB_VALUE: begin
            hw = half_word();
            if (is_orient) begin
              if (fields_good && hw >= 16'd1 && hw <= eop_pkg::MAX_ORIENT)
                orient_val = hw[3:0];
              else
                malformed = 1'b1;
            end
          end
          default: ;
        endcase
        if (byte_idx >= eop_pkg::ENTRY_LAST) begin
          byte_idx    = '0;
          fields_good = 1'b1;
          is_orient   = 1'b0;
          entry_idx   = entry_idx + 16'd1;
          if (entry_idx >= n_entries) ph = eop_pkg::PH_TAIL;
        end else begin
          byte_idx = byte_idx + 4'd1;
        end
      end
      eop_pkg::PH_TAIL: begin
        byte_idx = byte_idx + 4'd1;
        if (byte_idx >= eop_pkg::TAIL_BYTES) begin
          byte_idx = '0;
          ph       = eop_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
    if (pos_cnt != 32'hFFFF_FFFF) pos_cnt = pos_cnt + 32'd1;

    if (last) begin
      bad             = malformed || ph != eop_pkg::PH_DONE;
      res.invalid     = bad;
      res.present     = !bad && orient_val != 4'd0;
      res.orientation = bad ? 4'd0 : orient_val;
      done            = 1'b1;
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Block generator
  // ---------------------------------------------------------------------------

  task automatic add16(input logic [15:0] v);
    if (gen_be) begin
      blk_q.push_back(v[15:8]);
      blk_q.push_back(v[7:0]);
    end else begin
      blk_q.push_back(v[7:0]);
      blk_q.push_back(v[15:8]);
    end
  endtask

  task automatic add32(input logic [31:0] v);
    if (gen_be) begin
      add16(v[31:16]);
      add16(v[15:0]);
    end else begin
      add16(v[15:0]);
      add16(v[31:16]);
    end
  endtask

  // Mostly well-formed blocks with random content, the rest noise and
  // broken headers; some are cut short
  task automatic gen_block();
    int          kind;
    int          n;
    int          emit;
    int          orient_at;
    int          dup_at;
    int          off;
    int          cut;
    byte_item_t  item;
    logic [15:0] val;
    kind = $urandom_range(0, 99);
    blk_q.delete();
    if (kind < 10) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) blk_q.push_back(8'($urandom));
    end else begin
      gen_be = 1'($urandom_range(0, 1));
      if (kind < 18) begin
        if ($urandom_range(0, 1) != 0) begin
          blk_q.push_back(eop_pkg::MARK_II);
          blk_q.push_back(eop_pkg::MARK_MM);
        end else begin
          blk_q.push_back(8'($urandom));
          blk_q.push_back(8'($urandom));
        end
      end else begin
        blk_q.push_back(gen_be ? eop_pkg::MARK_MM : eop_pkg::MARK_II);
        blk_q.push_back(gen_be ? eop_pkg::MARK_MM : eop_pkg::MARK_II);
      end
      add16((kind >= 18 && kind < 24) ? 16'($urandom) : eop_pkg::TIFF_MAGIC);
      if (kind >= 24 && kind < 30) off = $urandom_range(0, 7);
      else off = 8 + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
      add32(32'(off));
      while (blk_q.size() < off) blk_q.push_back(8'($urandom));

      // directory: count, entries, next-directory link
      n    = $urandom_range(0, 3);
      emit = n;
      if ($urandom_range(0, 19) == 0) begin
        n    = $urandom_range(4, 16'hFFFF);
        emit = 2;
      end
      add16(16'(n));
      orient_at = $urandom_range(0, emit);
      dup_at    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, emit) : -1;
      for (int i = 0; i < emit; i++) begin
        if (i == orient_at || i == dup_at) begin
          add16(eop_pkg::ORIENT_TAG);
          add16(($urandom_range(0, 7) == 0) ? 16'($urandom) : eop_pkg::SHORT_TYPE);
          add32(($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'd1);
          case ($urandom_range(0, 7))
            0:       val = 16'd0;
            1:       val = 16'd9;
            2:       val = 16'($urandom);
            default: val = 16'($urandom_range(1, 8));
          endcase
          add16(val);
          add16(16'($urandom));
        end else begin
          add16(($urandom_range(0, 15) == 0) ? eop_pkg::ORIENT_TAG ^ 16'h0001
                                             : 16'($urandom));
          add16(16'($urandom));
          add32(32'($urandom));
          add32(32'($urandom));
        end
      end
      add32(32'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) blk_q.push_back(8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, blk_q.size() - 1);
        while (blk_q.size() > cut) void'(blk_q.pop_back());
      end
    end
    foreach (blk_q[i]) begin
      item.data  = blk_q[i];
      item.last  = (i == blk_q.size() - 1);
      item.typed = 1'b0;
      item.res   = RES_NONE;
      byte_q.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------

  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    bit          got;
    orient_res_t pred;
    if (rst_n) begin
      // accepted transaction: predict, then retire the item
      if (s_tvalid && s_tready) begin
        parse_tiff_byte(byte_q[0].data, byte_q[0].last, got, pred);
        if (got) orient_exp_q.push_back(byte_q[0].typed ? byte_q[0].res : pred);
        void'(byte_q.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_q[0].data;
          s_tlast  <= byte_q[0].last;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall patterns, one long hold-off, and the check
  // ---------------------------------------------------------------------------

  rx_mode_e rx_mode      = RX_OPEN;
  int       mode_left    = 0;
  int       rx_tick      = 0;
  int       holdoff_left = 0;
  bit       holdoff_done = 1'b0;

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    orient_res_t want;
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (orient_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected, expected none, actual 0x%02h",
                   $time, m_tdata);
        end else begin
          want = orient_exp_q.pop_front();
          check_field("invalid", want.invalid, m_tdata[0]);
          check_field("present", want.present, m_tdata[1]);
          check_field("orientation", want.orientation, m_tdata[5:2]);
          check_field("pad bits", 0, m_tdata[7:6]);
        end
      end

      if (holdoff_left != 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else if (!holdoff_done && results_seen >= 8) begin
        // long hold-off so the parser backs up into its input
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        rx_tick++;
        case (rx_mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
          default:   m_tready <= (rx_tick % 5) >= 2;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    byte_item_t item;
    int         rand_start;
    clear_parser();
    for (int i = 0; i < DIR_LEN; i++) begin
      item = DIR_ROWS[i];
      byte_q.push_back(item);
    end
    rand_start = byte_q.size();
    while (byte_q.size() - rand_start < RAND_BYTES) gen_block();

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (orient_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[exif_orientation_parser] OK");
    end else begin
      $display("[exif_orientation_parser] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(2_000_000);
    $display("[exif_orientation_parser] ERROR");
    $finish;
  end

endmodule
